FILE: rtl/assert_macros.svh
// assertion macros for the rtl files; only the class table module includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, ignored while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

FILE: rtl/kect_pkg.sv
// types, constants and helpers for the key equivalence class table
`default_nettype none

package kect_pkg;

  // class table size, tied to the width of the class id field
  localparam int MAX_CLASSES = 64;

  localparam int KEY_W  = 20;
  localparam int CNT_W  = 9;
  localparam int CLS_W  = $clog2(MAX_CLASSES + 1);
  localparam int MODE_W = 2;
  localparam int CODE_W = 5;
  localparam int IDX_W  = 8;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BIND  = 2'd3;

  localparam int KEY_BASE = 20;
  localparam logic [KEY_W-1:0] KEY_MUL1 = KEY_W'(KEY_BASE);
  localparam logic [KEY_W-1:0] KEY_MUL2 = KEY_W'(KEY_BASE * KEY_BASE);
  localparam logic [KEY_W-1:0] KEY_MUL3 = KEY_W'(KEY_BASE * KEY_BASE * KEY_BASE);

  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [CNT_W-1:0] COUNT_ONE = 9'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  entry_index;
    logic              entry_used;
    logic [CODE_W-1:0] element_code;
    logic [CODE_W-1:0] hybrid_code;
    logic [CODE_W-1:0] multiplicity_code;
    logic [CODE_W-1:0] charge_code;
    logic              already_bound;
    logic              correlating;
    logic              in_group;
  } kect_in_t;

  typedef struct packed {
    logic [CLS_W-1:0] class_id;
    logic [CNT_W-1:0] member_index;
    logic             usable;
    logic             status;
  } kect_out_t;

  // saturating member counter increment
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kect_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module kect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/key_equivalence_class_table.sv
// key equivalence class table: classifies entries by status key, one class member usable at a time
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   kect_in_t
//   out      output     out_valid/out_stall kect_out_t
//   cfg      input      cfg_wr_en           cfg_wr_data (1 bit)
//
// load: one stored key compared per cycle on the key ram port.
// build: entry sweep then counter sweep.
// test and bind: entry ram read then counter ram read.
// reset clears the per-entry class valid bits at once; no clearing pass.
// a new transaction is taken while the previous result waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module key_equivalence_class_table
  import kect_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  kect_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output kect_out_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  // entry index is 8 bits wide, so no more than 256 entries can be reached
  localparam int NUM_ENT = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
  localparam int EIW     = $clog2(NUM_ENT);
  localparam int ESW     = $clog2(NUM_ENT + 1);
  localparam int CIW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CCW     = $clog2(MAX_CLASSES + 1);
  localparam int ENT_W   = CIW + CNT_W;

  localparam logic [CLS_W-1:0] NO_CLASS_ID = CLS_W'(MAX_CLASSES);
  localparam logic [CCW-1:0]   CLS_FULL    = CCW'(MAX_CLASSES);
  localparam logic [ESW-1:0]   ENT_END     = ESW'(NUM_ENT);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_LHIT,
    ST_BSWEEP,
    ST_BCNT,
    ST_REP_E,
    ST_REP_C,
    ST_REP_D,
    ST_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [EIW-1:0]      xi_r, xi_nxt;
  logic                xok_r, xok_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CCW-1:0]      ptr_r, ptr_nxt;
  logic                iss_v_r, iss_v_nxt;
  logic [CIW-1:0]      iss_idx_r, iss_idx_nxt;
  logic [ESW-1:0]      e_ptr_r, e_ptr_nxt;
  logic                s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic [EIW-1:0]      s1_x_r, s1_x_nxt, s2_x_r, s2_x_nxt;
  logic [CIW-1:0]      cls_r, cls_nxt;
  logic [CNT_W-1:0]    mem_r, mem_nxt;
  logic [CCW-1:0]      cu_r, cu_nxt;
  logic [NUM_ENT-1:0]  has_cls_r, has_cls_nxt;
  kect_out_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  kect_out_t           out_data_r, out_data_nxt;
  logic                cfg_allow_r;

  // ram ports
  logic                key_we;
  logic [CIW-1:0]      key_waddr, key_raddr;
  logic [KEY_W-1:0]    key_wdata, key_rdata;
  logic                cnt_we;
  logic [CIW-1:0]      cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                ent_we;
  logic [EIW-1:0]      ent_waddr, ent_raddr;
  logic [ENT_W-1:0]    ent_wdata, ent_rdata;

  logic [CIW-1:0]      ent_rd_cls;
  logic [CNT_W-1:0]    ent_rd_mem;
  logic [CNT_W-1:0]    cnt_bumped;
  logic [KEY_W-1:0]    in_key;
  logic                in_xok;
  logic                in_excl;
  logic [EIW-1:0]      in_xi;
  logic [CIW-1:0]      cu_idx;

  assign ent_rd_cls = ent_rdata[CNT_W +: CIW];
  assign ent_rd_mem = ent_rdata[CNT_W-1:0];
  assign cnt_bumped = bump(cnt_rdata);
  assign cu_idx     = cu_r[CIW-1:0];

  assign in_key = KEY_W'(in_data.element_code)
                + KEY_W'(in_data.hybrid_code) * KEY_MUL1
                + KEY_W'(in_data.multiplicity_code) * KEY_MUL2
                + KEY_W'(in_data.charge_code) * KEY_MUL3;
  assign in_xok  = ({1'b0, in_data.entry_index} < 9'(NUM_ENT));
  assign in_xi   = in_data.entry_index[EIW-1:0];
  assign in_excl = ((in_data.element_code == '0) && !cfg_allow_r) || in_data.already_bound
                || in_data.correlating || in_data.in_group;

  kect_ram #(.WIDTH(KEY_W), .DEPTH(MAX_CLASSES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  kect_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLASSES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  kect_ram #(.WIDTH(ENT_W), .DEPTH(NUM_ENT)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    xi_nxt        = xi_r;
    xok_nxt       = xok_r;
    key_nxt       = key_r;
    ptr_nxt       = ptr_r;
    iss_v_nxt     = iss_v_r;
    iss_idx_nxt   = iss_idx_r;
    e_ptr_nxt     = e_ptr_r;
    s1_v_nxt      = s1_v_r;
    s1_x_nxt      = s1_x_r;
    s2_v_nxt      = s2_v_r;
    s2_x_nxt      = s2_x_r;
    cls_nxt       = cls_r;
    mem_nxt       = mem_r;
    cu_nxt        = cu_r;
    has_cls_nxt   = has_cls_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    key_we    = 1'b0;
    key_waddr = cu_idx;
    key_wdata = key_r;
    key_raddr = ptr_r[CIW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = cls_r;
    cnt_wdata = COUNT_ONE;
    cnt_raddr = ent_rd_cls;
    ent_we    = 1'b0;
    ent_waddr = xi_r;
    ent_wdata = {cls_r, COUNT_ONE};
    ent_raddr = (state_r == ST_BSWEEP) ? e_ptr_r[EIW-1:0] : xi_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          xi_nxt    = in_xi;
          xok_nxt   = in_xok;
          key_nxt   = in_key;
          ptr_nxt   = '0;
          iss_v_nxt = 1'b0;
          e_ptr_nxt = '0;
          s1_v_nxt  = 1'b0;
          s2_v_nxt  = 1'b0;
          res_nxt   = '{class_id: NO_CLASS_ID, member_index: '0, usable: 1'b1, status: 1'b0};
          case (in_data.mode)
            MODE_LOAD: begin
              if (!in_xok) begin
                state_nxt = ST_FIN;
              end else if (!in_data.entry_used || in_excl) begin
                has_cls_nxt[in_xi] = 1'b0;
                state_nxt          = ST_FIN;
              end else begin
                state_nxt = ST_SRCH;
              end
            end
            MODE_BUILD: state_nxt = ST_BSWEEP;
            default:    state_nxt = in_xok ? ST_REP_E : ST_FIN;
          endcase
        end
      end

      // one key read issued per cycle, compared against the search key in the cycle after its issue
      ST_SRCH: begin
        if (iss_v_r && (key_rdata == key_r)) begin
          cnt_raddr = iss_idx_r;
          cls_nxt   = iss_idx_r;
          state_nxt = ST_LHIT;
        end else if (ptr_r < cu_r) begin
          iss_v_nxt   = 1'b1;
          iss_idx_nxt = ptr_r[CIW-1:0];
          ptr_nxt     = ptr_r + 1'b1;
        end else if (!iss_v_r) begin
          if (cu_r == CLS_FULL) begin
            has_cls_nxt[xi_r] = 1'b0;
            res_nxt.status    = 1'b1;
          end else begin
            key_we            = 1'b1;
            cnt_we            = 1'b1;
            cnt_waddr         = cu_idx;
            ent_we            = 1'b1;
            ent_wdata         = {cu_idx, COUNT_ONE};
            has_cls_nxt[xi_r] = 1'b1;
            cu_nxt            = cu_r + 1'b1;
            res_nxt           = '{class_id: CLS_W'(cu_idx), member_index: COUNT_ONE,
                                  usable: 1'b1, status: 1'b0};
          end
          state_nxt = ST_FIN;
        end else begin
          iss_v_nxt = 1'b0;
        end
      end

      ST_LHIT: begin
        cnt_we            = 1'b1;
        cnt_wdata         = cnt_bumped;
        ent_we            = 1'b1;
        ent_wdata         = {cls_r, cnt_bumped};
        has_cls_nxt[xi_r] = 1'b1;
        res_nxt           = '{class_id: CLS_W'(cls_r), member_index: cnt_bumped,
                              usable: 1'b1, status: 1'b0};
        state_nxt         = ST_FIN;
      end

      // entry read, then counter read of its class, then drop singletons
      ST_BSWEEP: begin
        if (e_ptr_r < ENT_END) begin
          s1_v_nxt  = 1'b1;
          s1_x_nxt  = e_ptr_r[EIW-1:0];
          e_ptr_nxt = e_ptr_r + 1'b1;
        end else begin
          s1_v_nxt = 1'b0;
        end
        s2_v_nxt = s1_v_r;
        s2_x_nxt = s1_x_r;
        if (s2_v_r && has_cls_r[s2_x_r] && (cnt_rdata == COUNT_ONE)) begin
          has_cls_nxt[s2_x_r] = 1'b0;
        end
        if ((e_ptr_r >= ENT_END) && !s1_v_r && !s2_v_r) begin
          ptr_nxt   = '0;
          state_nxt = ST_BCNT;
        end
      end

      ST_BCNT: begin
        if (ptr_r < cu_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = ptr_r[CIW-1:0];
          ptr_nxt   = ptr_r + 1'b1;
        end else begin
          state_nxt = xok_r ? ST_REP_E : ST_FIN;
        end
      end

      ST_REP_E: state_nxt = ST_REP_C;

      ST_REP_C: begin
        cls_nxt   = ent_rd_cls;
        mem_nxt   = ent_rd_mem;
        state_nxt = ST_REP_D;
      end

      ST_REP_D: begin
        if (has_cls_r[xi_r]) begin
          if (mode_r == MODE_BIND) begin
            cnt_we            = 1'b1;
            cnt_wdata         = cnt_bumped;
            has_cls_nxt[xi_r] = 1'b0;
          end else begin
            res_nxt = '{class_id: CLS_W'(cls_r), member_index: mem_r,
                        usable: (mem_r == cnt_rdata), status: 1'b0};
          end
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_v_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      cu_r        <= '0;
      has_cls_r   <= '0;
      out_valid_r <= 1'b0;
      cfg_allow_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_v_r     <= iss_v_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      cu_r        <= cu_nxt;
      has_cls_r   <= has_cls_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_allow_r <= cfg_wr_data;
      end
    end
    mode_r     <= mode_nxt;
    xi_r       <= xi_nxt;
    xok_r      <= xok_nxt;
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    iss_idx_r  <= iss_idx_nxt;
    e_ptr_r    <= e_ptr_nxt;
    s1_x_r     <= s1_x_nxt;
    s2_x_r     <= s2_x_nxt;
    cls_r      <= cls_nxt;
    mem_r      <= mem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_cu_bound, cu_r > CLS_FULL, "class count beyond table size")
  `ASSERT_CLK(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall,
              "input taken again before the transaction finished")
  `ASSERT_CLK(a_full_status, (out_valid && out_data.status) |-> (cu_r == CLS_FULL),
              "table full reported while classes remain")
  `ASSERT_CLK(a_no_member_usable, (out_valid && (out_data.member_index == '0)) |->
              (out_data.usable && (out_data.class_id == NO_CLASS_ID)),
              "entry without member index has a class or is not usable")

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for the key equivalence class table: directed table, then predictor-checked traffic
module testbench;
  import kect_pkg::*;

  localparam int          ENTRY_COUNT   = 256;
  localparam int          CLASS_LIMIT   = 64;
  localparam logic [6:0]  NO_CLASS      = 7'd64;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          POOL_SIZE     = 6;

  typedef enum {MIX_POOL, MIX_SATURATE, MIX_FILL} traffic_mix_t;

  typedef struct {
    logic      zero_class_mode;
    kect_in_t  item;
    bit        typed;
    kect_out_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  kect_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  kect_out_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  // predictor state
  logic             ent_valid  [ENTRY_COUNT];
  logic [CLS_W-1:0] ent_class  [ENTRY_COUNT];
  logic [CNT_W-1:0] ent_member [ENTRY_COUNT];
  logic [KEY_W-1:0] cls_key    [CLASS_LIMIT];
  logic [CNT_W-1:0] cls_count  [CLASS_LIMIT];
  int               n_classes;
  logic             allow_zero;

  kect_out_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  int unsigned stall_style = 0;

  logic [CODE_W-1:0] pool_codes [POOL_SIZE][4];
  logic [CODE_W-1:0] sat_codes  [4];

  key_equivalence_class_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic bit in_class(input int x);
    return ent_valid[x] && (int'(ent_class[x]) < n_classes);
  endfunction

  function automatic kect_out_t classify_step(input kect_in_t it);
    kect_out_t        res;
    int               x;
    int               slot;
    bit               hit;
    logic [KEY_W-1:0] key;
    res.class_id     = NO_CLASS;
    res.member_index = '0;
    res.usable       = 1'b1;
    res.status       = 1'b0;
    x = int'(it.entry_index);
    if (it.mode == MODE_BUILD) begin
      for (int e = 0; e < ENTRY_COUNT; e++)
        if (in_class(e) && cls_count[ent_class[e]] == 9'd1) ent_class[e] = NO_CLASS;
      for (int i = 0; i < n_classes; i++) cls_count[i] = 9'd1;
    end
    if (it.mode == MODE_LOAD) begin
      ent_class[x]  = NO_CLASS;
      ent_member[x] = '0;
      ent_valid[x]  = it.entry_used;
      if (it.entry_used && !((it.element_code == '0 && !allow_zero) || it.already_bound ||
                             it.correlating || it.in_group)) begin
        key = KEY_W'(int'(it.element_code) + KEY_BASE * (int'(it.hybrid_code) +
              KEY_BASE * (int'(it.multiplicity_code) + KEY_BASE * int'(it.charge_code))));
        hit  = 1'b0;
        slot = 0;
        for (int i = 0; i < n_classes; i++)
          if (!hit && cls_key[i] == key) begin
            hit  = 1'b1;
            slot = i;
          end
        if (hit) begin
          cls_count[slot] = sat_inc(cls_count[slot]);
          ent_class[x]    = CLS_W'(slot);
          ent_member[x]   = cls_count[slot];
        end else if (n_classes >= CLASS_LIMIT) begin
          res.status = 1'b1;
        end else begin
          slot            = n_classes;
          n_classes++;
          cls_key[slot]   = key;
          cls_count[slot] = 9'd1;
          ent_class[x]    = CLS_W'(slot);
          ent_member[x]   = 9'd1;
        end
      end
    end else if (it.mode == MODE_BIND && in_class(x)) begin
      cls_count[ent_class[x]] = sat_inc(cls_count[ent_class[x]]);
      ent_class[x] = NO_CLASS;
    end
    if (in_class(x)) begin
      res.class_id     = ent_class[x];
      res.member_index = ent_member[x];
      res.usable       = (ent_member[x] == cls_count[ent_class[x]]);
    end
    return res;
  endfunction

  function automatic kect_in_t make_in(input logic [MODE_W-1:0] mode, input int idx,
                                       input bit used, input int el, input int hy,
                                       input int mu, input int ch, input bit bound,
                                       input bit corr, input bit grp);
    kect_in_t it;
    it.mode              = mode;
    it.entry_index       = IDX_W'(idx);
    it.entry_used        = used;
    it.element_code      = CODE_W'(el);
    it.hybrid_code       = CODE_W'(hy);
    it.multiplicity_code = CODE_W'(mu);
    it.charge_code       = CODE_W'(ch);
    it.already_bound     = bound;
    it.correlating       = corr;
    it.in_group          = grp;
    return it;
  endfunction

  function automatic kect_out_t class_result(input int cls, input int mem, input bit ok,
                                             input bit st);
    kect_out_t r;
    r.class_id     = CLS_W'(cls);
    r.member_index = CNT_W'(mem);
    r.usable       = ok;
    r.status       = st;
    return r;
  endfunction

  function automatic kect_in_t random_item(input traffic_mix_t mix);
    kect_in_t    it;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    case (mix)
      MIX_SATURATE: it.mode = (r < 95) ? MODE_LOAD : (r < 97) ? MODE_TEST : MODE_BIND;
      MIX_FILL:     it.mode = (r < 80) ? MODE_LOAD : (r < 85) ? MODE_BUILD :
                              (r < 93) ? MODE_TEST : MODE_BIND;
      default:      it.mode = (r < 50) ? MODE_LOAD : (r < 60) ? MODE_BUILD :
                              (r < 80) ? MODE_TEST : MODE_BIND;
    endcase
    // pool traffic stays mostly on a few entries so classes gain several members
    if (mix == MIX_POOL && $urandom_range(9) != 0) it.entry_index = IDX_W'($urandom_range(31));
    else it.entry_index = IDX_W'($urandom_range(255));
    it.entry_used    = ($urandom_range(19) != 0);
    it.already_bound = ($urandom_range(14) == 0);
    it.correlating   = ($urandom_range(14) == 0);
    it.in_group      = ($urandom_range(14) == 0);
    k = $urandom_range(POOL_SIZE - 1);
    it.element_code      = pool_codes[k][0];
    it.hybrid_code       = pool_codes[k][1];
    it.multiplicity_code = pool_codes[k][2];
    it.charge_code       = pool_codes[k][3];
    if (mix == MIX_SATURATE && it.mode == MODE_LOAD) begin
      // clean loads of one key drive its counter into saturation
      it.entry_used        = 1'b1;
      it.already_bound     = 1'b0;
      it.correlating       = 1'b0;
      it.in_group          = 1'b0;
      it.element_code      = sat_codes[0];
      it.hybrid_code       = sat_codes[1];
      it.multiplicity_code = sat_codes[2];
      it.charge_code       = sat_codes[3];
    end else if (mix == MIX_FILL && $urandom_range(9) != 0) begin
      it.element_code      = CODE_W'($urandom_range(19));
      it.hybrid_code       = CODE_W'($urandom_range(19));
      it.multiplicity_code = CODE_W'($urandom_range(19));
      it.charge_code       = CODE_W'($urandom_range(19));
    end
    return it;
  endfunction

  task automatic add_row(input logic zmode, input kect_in_t it, input bit typed,
                         input kect_out_t want);
    stim_row_t row;
    row.zero_class_mode = zmode;
    row.item            = it;
    row.typed           = typed;
    row.want            = want;
    directed_rows.push_back(row);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input kect_in_t it, input bit typed, input kect_out_t want);
    kect_out_t guess;
    if (burst_left == 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    guess = classify_step(it);
    pending_results.push_back(typed ? want : guess);
  endtask

  task automatic set_zero_class_mode(input logic v);
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    allow_zero = v;
  endtask

  task automatic run_random(input traffic_mix_t mix, input int count);
    for (int n = 0; n < count; n++) send_item(random_item(mix), 1'b0, '0);
  endtask

  // result side: compare each transaction with the oldest expectation, stall on its own pattern
  always @(posedge clk) begin : result_check
    kect_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.class_id !== want.class_id) begin
          $display("%0t class_id: expected %0d, got %0d", $time, want.class_id,
                   out_data.class_id);
          mismatches++;
        end
        if (out_data.member_index !== want.member_index) begin
          $display("%0t member_index: expected %0d, got %0d", $time, want.member_index,
                   out_data.member_index);
          mismatches++;
        end
        if (out_data.usable !== want.usable) begin
          $display("%0t usable: expected %0d, got %0d", $time, want.usable, out_data.usable);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t status: expected %0d, got %0d", $time, want.status, out_data.status);
          mismatches++;
        end
      end
    end
    if (stall_run == 0) begin
      stall_style = $urandom_range(3);
      stall_run   = $urandom_range(5, 60);
    end
    stall_run--;
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(9) < 3);
      2:       out_stall <= ($urandom_range(9) < 7);
      default: out_stall <= (stall_run % 3 == 0);
    endcase
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    allow_zero  = 1'b0;
    n_classes   = 0;
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      ent_valid[e]  = 1'b0;
      ent_class[e]  = NO_CLASS;
      ent_member[e] = '0;
    end
    for (int i = 0; i < CLASS_LIMIT; i++) begin
      cls_key[i]   = '0;
      cls_count[i] = '0;
    end
    for (int k = 0; k < POOL_SIZE; k++)
      for (int f = 0; f < 4; f++) pool_codes[k][f] = CODE_W'($urandom_range(19));
    pool_codes[0][0] = '0;  // one pool key only classes when element-zero classes are on
    sat_codes[0] = CODE_W'($urandom_range(1, 19));
    for (int f = 1; f < 4; f++) sat_codes[f] = CODE_W'($urandom_range(19));

    add_row(0, make_in(MODE_TEST, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_BIND, 255, 1, 19, 19, 19, 19, 1, 1, 1), 1,
            class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 0, 1, 0, 19, 19, 19, 0, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 1, 1, 19, 19, 19, 19, 0, 0, 0), 1, class_result(0, 1, 1, 0));
    add_row(0, make_in(MODE_LOAD, 2, 1, 19, 19, 19, 19, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_LOAD, 3, 1, 19, 19, 19, 19, 1, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 4, 1, 19, 19, 19, 19, 0, 1, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 5, 1, 19, 19, 19, 19, 0, 0, 1), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 6, 0, 19, 19, 19, 19, 0, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 7, 1, 1, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_TEST, 1, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_BUILD, 1, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_TEST, 7, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_TEST, 2, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_BIND, 1, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_TEST, 2, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_LOAD, 1, 0, 19, 19, 19, 19, 0, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_LOAD, 2, 1, 19, 19, 19, 19, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_LOAD, 8, 1, 19, 0, 19, 0, 0, 0, 0), 0, '0);
    add_row(0, make_in(MODE_BIND, 200, 1, 0, 0, 0, 0, 0, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(0, make_in(MODE_BUILD, 255, 1, 0, 0, 0, 0, 0, 0, 0), 1, class_result(64, 0, 1, 0));
    add_row(1, make_in(MODE_LOAD, 9, 1, 0, 5, 3, 2, 0, 0, 0), 0, '0);
    add_row(1, make_in(MODE_LOAD, 10, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(1, make_in(MODE_TEST, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, class_result(64, 0, 1, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].zero_class_mode != allow_zero)
        set_zero_class_mode(directed_rows[r].zero_class_mode);
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    set_zero_class_mode(1'b0);
    run_random(MIX_POOL, 220);
    set_zero_class_mode(1'b1);
    run_random(MIX_POOL, 130);
    set_zero_class_mode(1'b0);
    run_random(MIX_SATURATE, 580);
    // fresh keys run the class table out of room
    set_zero_class_mode(1'b1);
    run_random(MIX_FILL, 150);

    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
